### rtl/swscf_pkg.sv
// ----------------------------------------------------------------------------
// swscf_pkg: shared types and constants of the sigma clip flagger
// lane command and status groups, register indexes, fixed field widths
// ----------------------------------------------------------------------------
package swscf_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_LEN   = 2'd0;
  localparam logic [1:0] REG_SIGMA_GAIN   = 2'd1;
  localparam logic [1:0] REG_SPREAD_CHECK = 2'd2;

  localparam int WLEN_W   = 6;
  localparam int GAIN_W   = 16;
  localparam int TOTAL_W  = 16;
  localparam int SEEN_W   = 7;

  // 20 squared, for the spread test 400*D > S*S
  localparam int SPREAD_SQ = 400;

  // command from the sequencer to each channel lane
  typedef struct packed {
    logic upd;       // fold a new sample into the window sums
    logic drop;      // with upd: remove the sample leaving the window
    logic clr;       // clear all window sums at set end
    logic prep;      // derive window terms for the judge
    logic sel_prev;  // with prep: use the previous window
    logic judge;     // test one sample against the prepared window
  } lane_cmd_t;

  // status back from a lane
  typedef struct packed {
    logic done;
    logic hit;
  } lane_sts_t;

endpackage

### rtl/swscf_ram.sv
// ----------------------------------------------------------------------------
// swscf_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module swscf_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/swscf_mul.sv
// ----------------------------------------------------------------------------
// swscf_mul: iterative multiplier
// wide by wide product, 16 bits of the b operand per cycle, truncated to PW
// ----------------------------------------------------------------------------
module swscf_mul #(
  parameter int PW = 76
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] a,
  input  logic [PW-1:0] b,
  output logic [PW-1:0] p,
  output logic          done
);

  localparam int NDIG = (PW + 15) / 16;
  localparam int CW   = $clog2(NDIG + 1);

  logic [PW-1:0]    a_r, a_nxt;
  logic [PW-1:0]    b_r, b_nxt;
  logic [PW-1:0]    acc_r, acc_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [PW+15:0]   pp;

  assign pp = a_r * b_r[15:0];

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = CW'(NDIG);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp[PW-1:0];
      a_nxt   = a_r << 16;
      b_nxt   = b_r >> 16;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign p    = acc_r;
  assign done = done_r;

endmodule

### rtl/swscf_lane.sv
// ----------------------------------------------------------------------------
// swscf_lane: one channel of the flagger
// keeps running window sums and squares, tests samples exactly in integers
// ----------------------------------------------------------------------------
module swscf_lane #(
  parameter int SB = 16,
  parameter int LW = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swscf_pkg::lane_cmd_t            cmd,
  input  logic [LW-1:0]                   len,
  input  logic [swscf_pkg::GAIN_W-1:0]    sigma_gain,
  input  logic                            spread_check,
  input  logic [SB-1:0]                   x,
  input  logic [SB-1:0]                   y,
  output swscf_pkg::lane_sts_t            sts
);

  localparam int SW = SB + LW;
  localparam int QW = 2 * SB + LW;
  localparam int DW = 2 * SB + 2 * LW;
  localparam int PW = DW + 32;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_SQ   = 3'd1;
  localparam logic [2:0] L_ACC  = 3'd2;
  localparam logic [2:0] L_PSW  = 3'd3;
  localparam logic [2:0] L_PGW  = 3'd4;
  localparam logic [2:0] L_PDW  = 3'd5;
  localparam logic [2:0] L_JW   = 3'd6;

  logic [2:0]      st_r, st_nxt;
  logic [SW-1:0]   s_cur_r, s_cur_nxt, s_prv_r, s_prv_nxt, ws_r, ws_nxt;
  logic [QW-1:0]   q_cur_r, q_cur_nxt, q_prv_r, q_prv_nxt, wq_r, wq_nxt;
  logic [DW-1:0]   ss_r, ss_nxt, d_r, d_nxt;
  logic [PW-1:0]   gd_r, gd_nxt;
  logic            sprd_r, sprd_nxt;
  logic [SB-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic            drop_r, drop_nxt;
  logic [2*SB-1:0] xsq_r, xsq_nxt, ysq_r, ysq_nxt;
  logic            hit_r, hit_nxt;
  logic            done_r, done_nxt;

  logic            m_start, m_done;
  logic [PW-1:0]   m_a, m_b, m_p;

  logic [SW-1:0]   ws_sel;
  logic [QW-1:0]   wq_sel;
  logic [SW-1:0]   lx;
  logic [SW-1:0]   adev;
  logic [DW-1:0]   lq;
  logic [DW+8:0]   d400;
  logic            sp_hit;

  assign ws_sel = cmd.sel_prev ? s_prv_r : s_cur_r;
  assign wq_sel = cmd.sel_prev ? q_prv_r : q_cur_r;
  assign lx     = SW'(len) * SW'(x);
  assign adev   = lx - ws_r;
  assign lq     = DW'(len) * DW'(wq_r);
  assign d400   = (DW+9)'(d_r) * (DW+9)'(swscf_pkg::SPREAD_SQ);
  assign sp_hit = spread_check & sprd_r;

  swscf_mul #(.PW(PW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m_start),
    .a     (m_a),
    .b     (m_b),
    .p     (m_p),
    .done  (m_done)
  );

  always_comb begin
    st_nxt    = st_r;
    s_cur_nxt = s_cur_r;
    s_prv_nxt = s_prv_r;
    q_cur_nxt = q_cur_r;
    q_prv_nxt = q_prv_r;
    ws_nxt    = ws_r;
    wq_nxt    = wq_r;
    ss_nxt    = ss_r;
    d_nxt     = d_r;
    gd_nxt    = gd_r;
    sprd_nxt  = sprd_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    drop_nxt  = drop_r;
    xsq_nxt   = xsq_r;
    ysq_nxt   = ysq_r;
    hit_nxt   = hit_r;
    done_nxt  = 1'b0;
    m_start   = 1'b0;
    m_a       = '0;
    m_b       = '0;
    case (st_r)
      L_IDLE: begin
        if (cmd.clr) begin
          s_cur_nxt = '0;
          s_prv_nxt = '0;
          q_cur_nxt = '0;
          q_prv_nxt = '0;
        end else if (cmd.upd) begin
          x_nxt    = x;
          y_nxt    = y;
          drop_nxt = cmd.drop;
          st_nxt   = L_SQ;
        end else if (cmd.prep) begin
          ws_nxt  = ws_sel;
          wq_nxt  = wq_sel;
          m_start = 1'b1;
          m_a     = PW'(ws_sel);
          m_b     = PW'(ws_sel);
          st_nxt  = L_PSW;
        end else if (cmd.judge) begin
          if (lx > ws_r) begin
            m_start = 1'b1;
            m_a     = PW'(adev);
            m_b     = PW'(adev);
            st_nxt  = L_JW;
          end else begin
            hit_nxt  = sp_hit;
            done_nxt = 1'b1;
          end
        end
      end
      L_SQ: begin
        xsq_nxt = (2*SB)'(x_r) * (2*SB)'(x_r);
        ysq_nxt = (2*SB)'(y_r) * (2*SB)'(y_r);
        st_nxt  = L_ACC;
      end
      L_ACC: begin
        s_prv_nxt = s_cur_r;
        q_prv_nxt = q_cur_r;
        s_cur_nxt = s_cur_r + SW'(x_r) - (drop_r ? SW'(y_r) : SW'(0));
        q_cur_nxt = q_cur_r + QW'(xsq_r) - (drop_r ? QW'(ysq_r) : QW'(0));
        done_nxt  = 1'b1;
        st_nxt    = L_IDLE;
      end
      L_PSW: begin
        // S*S ready, D = L*Q - S*S, then gain squared
        if (m_done) begin
          ss_nxt  = m_p[DW-1:0];
          d_nxt   = lq - m_p[DW-1:0];
          m_start = 1'b1;
          m_a     = PW'(sigma_gain);
          m_b     = PW'(sigma_gain);
          st_nxt  = L_PGW;
        end
      end
      L_PGW: begin
        if (m_done) begin
          sprd_nxt = d400 > (DW+9)'(ss_r);
          m_start  = 1'b1;
          m_a      = PW'(m_p[31:0]);
          m_b      = PW'(d_r);
          st_nxt   = L_PDW;
        end
      end
      L_PDW: begin
        if (m_done) begin
          gd_nxt   = m_p;
          done_nxt = 1'b1;
          st_nxt   = L_IDLE;
        end
      end
      L_JW: begin
        // (256*A)^2 against G^2 * D
        if (m_done) begin
          hit_nxt  = ({m_p[PW-17:0], 16'd0} > gd_r) || sp_hit;
          done_nxt = 1'b1;
          st_nxt   = L_IDLE;
        end
      end
      default: begin
        st_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= L_IDLE;
      s_cur_r <= '0;
      s_prv_r <= '0;
      q_cur_r <= '0;
      q_prv_r <= '0;
      hit_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      s_cur_r <= s_cur_nxt;
      s_prv_r <= s_prv_nxt;
      q_cur_r <= q_cur_nxt;
      q_prv_r <= q_prv_nxt;
      hit_r   <= hit_nxt;
      done_r  <= done_nxt;
    end
    ws_r   <= ws_nxt;
    wq_r   <= wq_nxt;
    ss_r   <= ss_nxt;
    d_r    <= d_nxt;
    gd_r   <= gd_nxt;
    sprd_r <= sprd_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    drop_r <= drop_nxt;
    xsq_r  <= xsq_nxt;
    ysq_r  <= ysq_nxt;
  end

  assign sts.done = done_r;
  assign sts.hit  = hit_r;

endmodule

### rtl/sliding_window_sigma_clip_flagger.sv
// ----------------------------------------------------------------------------
// sliding_window_sigma_clip_flagger: two channel sliding window sigma clipper
// buffers periods, flags outliers against a centered window, in input order
// ----------------------------------------------------------------------------
// Each item is one integration period with two power samples and a prior
// flag. Per channel a period is flagged when its sample exceeds the window
// mean plus sigma_gain (8.8) standard deviations, or, with spread_check set,
// when twenty deviations exceed the mean; both tests are exact on integer
// window sums. The window_len latched at the first item of a set fixes the
// window; a set no longer than the window passes unjudged at its last item.
// Results leave in input order, with a saturating count of new flags. Items
// are taken one at a time: an item that yields no result passes through accept,
// memory read and the sum update in the two lanes. Each window change costs
// three passes of the lane multiplier (S*S, gain squared, gain squared times
// D), and each judged sample above the window mean one more pass. A pass
// covers NDIG digits of 16 bits; NDIG is (2*SAMPLE_BITS+2*clog2(WINDOW_MAX+1)
// +32)/16 rounded up, five at the defaults. The memory needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module sliding_window_sigma_clip_flagger #(
  parameter int WINDOW_MAX  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [swscf_pkg::GAIN_W-1:0]    cfg_wdata,
  // period items in
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_BITS-1:0]          in_power_a,
  input  logic [SAMPLE_BITS-1:0]          in_power_b,
  input  logic                            in_flag_in,
  input  logic                            in_last,
  // result items out
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_rfi_flag,
  output logic                            out_new_flag,
  output logic [swscf_pkg::TOTAL_W-1:0]   out_flagged_total,
  output logic                            out_last_res
);

  localparam int DEPTH = WINDOW_MAX + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PCW   = $clog2(DEPTH + 1);
  localparam int LW    = $clog2(WINDOW_MAX + 1);
  localparam int SB    = SAMPLE_BITS;
  localparam int RW    = 2 * SB + 1;
  localparam int WLW   = swscf_pkg::WLEN_W;
  localparam int SNW   = swscf_pkg::SEEN_W;
  localparam int TW    = swscf_pkg::TOTAL_W;

  // sequencer states
  localparam logic [3:0] T_IDLE  = 4'd0;
  localparam logic [3:0] T_RD    = 4'd1;
  localparam logic [3:0] T_UPW   = 4'd2;
  localparam logic [3:0] T_PREP  = 4'd3;
  localparam logic [3:0] T_PREPW = 4'd4;
  localparam logic [3:0] T_EMRD  = 4'd5;
  localparam logic [3:0] T_EMJ   = 4'd6;
  localparam logic [3:0] T_EMJW  = 4'd7;
  localparam logic [3:0] T_EMOUT = 4'd8;

  // configuration
  logic [WLW-1:0]                   wl_r, wl_nxt;
  logic [swscf_pkg::GAIN_W-1:0]     sg_r, sg_nxt;
  logic                             sc_r, sc_nxt;

  // sequencer state
  logic [3:0]     state_r, state_nxt;
  logic [LW-1:0]  len_r, len_nxt;        // window length latched per set
  logic [SNW-1:0] seen_r, seen_nxt;      // periods of this set, saturating
  logic [SNW-1:0] k_r, k_nxt;            // seen count before this item
  logic [PCW-1:0] pend_r, pend_nxt;      // items buffered without a result
  logic [AW-1:0]  wptr_r, wptr_nxt;      // next memory slot to write
  logic [AW-1:0]  tail_r, tail_nxt;      // oldest item still pending
  logic [SB-1:0]  xa_r, xa_nxt, xb_r, xb_nxt;
  logic           lst_r, lst_nxt;
  logic           ph_r, ph_nxt;          // 0 while emitting the lead group
  logic           all_r, all_nxt;        // group runs until nothing pends
  logic           judge_r, judge_nxt;    // 0 passes items through unchanged
  logic           sel_r, sel_nxt;        // group uses the previous window
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic [1:0]     dn_r, dn_nxt;
  logic           flag_r, flag_nxt;
  logic [TW-1:0]  total_r, total_nxt;

  // output register
  logic           ov_r, ov_nxt;
  logic           of_r, of_nxt;
  logic           on_r, on_nxt;
  logic [TW-1:0]  ot_r, ot_nxt;
  logic           ol_r, ol_nxt;

  // memory
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [RW-1:0]  ram_wdata, ram_rdata;
  logic [SB-1:0]  rd_a, rd_b;
  logic           rd_fin;

  // lanes
  swscf_pkg::lane_cmd_t cmd;
  swscf_pkg::lane_sts_t sts_a, sts_b;
  logic [SB-1:0]        lane_xa, lane_xb;

  logic           accept;
  logic [LW-1:0]  len_eff;
  logic [AW:0]    drop_sum;
  logic [AW-1:0]  drop_addr;
  logic           both_dn;
  logic           kge, keq;
  logic           fl_new;
  logic           grp_end;

  assign accept = in_valid && in_ready;
  assign {rd_fin, rd_b, rd_a} = ram_rdata;
  assign ram_wdata = {in_flag_in, in_power_b, in_power_a};
  assign both_dn = &(dn_r | {sts_b.done, sts_a.done});
  assign kge = k_r >= SNW'(len_r);
  assign keq = k_r == SNW'(len_r);

  // window length clamped to 1..WINDOW_MAX, latched on the set's first item
  always_comb begin
    if (seen_r != '0) begin
      len_eff = len_r;
    end else if (wl_r == '0) begin
      len_eff = LW'(1);
    end else if (wl_r > WLW'(WINDOW_MAX)) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = wl_r[LW-1:0];
    end
  end

  // slot of the sample leaving the window: len_eff writes back
  assign drop_sum  = {1'b0, wptr_r} + (AW+1)'(DEPTH) - (AW+1)'(len_eff);
  assign drop_addr = (drop_sum >= (AW+1)'(DEPTH)) ? AW'(drop_sum - (AW+1)'(DEPTH))
                                                  : drop_sum[AW-1:0];

  // lane sample inputs: new item on update, buffered item on judge
  assign lane_xa = (state_r == T_RD) ? xa_r : rd_a;
  assign lane_xb = (state_r == T_RD) ? xb_r : rd_b;

  // the tested item is new to the flag count only if not flagged on input
  assign fl_new  = flag_r && !rd_fin;
  assign grp_end = all_r ? (pend_r == PCW'(1)) : (cnt_r == LW'(1));

  always_comb begin
    wl_nxt    = wl_r;
    sg_nxt    = sg_r;
    sc_nxt    = sc_r;
    state_nxt = state_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    wptr_nxt  = wptr_r;
    tail_nxt  = tail_r;
    xa_nxt    = xa_r;
    xb_nxt    = xb_r;
    lst_nxt   = lst_r;
    ph_nxt    = ph_r;
    all_nxt   = all_r;
    judge_nxt = judge_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    dn_nxt    = dn_r;
    flag_nxt  = flag_r;
    total_nxt = total_r;
    ov_nxt    = ov_r && !out_ready;
    of_nxt    = of_r;
    on_nxt    = on_r;
    ot_nxt    = ot_r;
    ol_nxt    = ol_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = tail_r;
    cmd       = '0;
    in_ready  = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        swscf_pkg::REG_WINDOW_LEN:   wl_nxt = cfg_wdata[WLW-1:0];
        swscf_pkg::REG_SIGMA_GAIN:   sg_nxt = cfg_wdata;
        swscf_pkg::REG_SPREAD_CHECK: sc_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      T_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          // store the item and fetch the one leaving the window
          xa_nxt    = in_power_a;
          xb_nxt    = in_power_b;
          lst_nxt   = in_last;
          len_nxt   = len_eff;
          k_nxt     = seen_r;
          seen_nxt  = (seen_r == {SNW{1'b1}}) ? seen_r : seen_r + 1'b1;
          pend_nxt  = pend_r + 1'b1;
          wptr_nxt  = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
          ram_we    = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = drop_addr;
          state_nxt = T_RD;
        end
      end
      T_RD: begin
        cmd.upd   = 1'b1;
        cmd.drop  = kge;
        dn_nxt    = '0;
        state_nxt = T_UPW;
      end
      T_UPW: begin
        dn_nxt = dn_r | {sts_b.done, sts_a.done};
        if (both_dn) begin
          dn_nxt = '0;
          if (!kge) begin
            // window not yet full: a short set passes through at its end
            if (lst_r) begin
              judge_nxt = 1'b0;
              all_nxt   = 1'b1;
              ph_nxt    = 1'b1;
              state_nxt = T_EMRD;
            end else begin
              state_nxt = T_IDLE;
            end
          end else if (keq) begin
            // first full window: the leading half plus one use it
            judge_nxt = 1'b1;
            ph_nxt    = 1'b0;
            sel_nxt   = 1'b1;
            all_nxt   = 1'b0;
            cnt_nxt   = (len_r >> 1) + 1'b1;
            state_nxt = T_PREP;
          end else begin
            judge_nxt = 1'b1;
            ph_nxt    = 1'b1;
            sel_nxt   = lst_r && !len_r[0];
            all_nxt   = lst_r;
            cnt_nxt   = LW'(1);
            state_nxt = T_PREP;
          end
        end
      end
      T_PREP: begin
        cmd.prep     = 1'b1;
        cmd.sel_prev = sel_r;
        dn_nxt       = '0;
        state_nxt    = T_PREPW;
      end
      T_PREPW: begin
        dn_nxt = dn_r | {sts_b.done, sts_a.done};
        if (both_dn) begin
          dn_nxt    = '0;
          state_nxt = T_EMRD;
        end
      end
      T_EMRD: begin
        ram_re    = 1'b1;
        ram_raddr = tail_r;
        state_nxt = T_EMJ;
      end
      T_EMJ: begin
        if (judge_r) begin
          cmd.judge = 1'b1;
          dn_nxt    = '0;
          state_nxt = T_EMJW;
        end else begin
          flag_nxt  = rd_fin;
          state_nxt = T_EMOUT;
        end
      end
      T_EMJW: begin
        dn_nxt = dn_r | {sts_b.done, sts_a.done};
        if (both_dn) begin
          dn_nxt    = '0;
          flag_nxt  = rd_fin || sts_a.hit || sts_b.hit;
          state_nxt = T_EMOUT;
        end
      end
      T_EMOUT: begin
        if (!ov_r || out_ready) begin
          if (fl_new && total_r != {TW{1'b1}}) begin
            total_nxt = total_r + 1'b1;
            ot_nxt    = total_r + 1'b1;
          end else begin
            ot_nxt    = total_r;
          end
          ov_nxt   = 1'b1;
          of_nxt   = flag_r;
          on_nxt   = fl_new;
          ol_nxt   = lst_r && (pend_r == PCW'(1));
          tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
          pend_nxt = pend_r - 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
          if (!grp_end) begin
            state_nxt = T_EMRD;
          end else if (!ph_r) begin
            // lead group done, continue with this item's own group
            ph_nxt    = 1'b1;
            sel_nxt   = lst_r && !len_r[0];
            all_nxt   = lst_r;
            cnt_nxt   = LW'(1);
            state_nxt = T_PREP;
          end else begin
            if (lst_r) begin
              // end of set: windows restart with the next item
              cmd.clr  = 1'b1;
              seen_nxt = '0;
              pend_nxt = '0;
            end
            state_nxt = T_IDLE;
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  swscf_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swscf_lane #(.SB(SB), .LW(LW)) u_lane_a (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .len          (len_r),
    .sigma_gain   (sg_r),
    .spread_check (sc_r),
    .x            (lane_xa),
    .y            (rd_a),
    .sts          (sts_a)
  );

  swscf_lane #(.SB(SB), .LW(LW)) u_lane_b (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .len          (len_r),
    .sigma_gain   (sg_r),
    .spread_check (sc_r),
    .x            (lane_xb),
    .y            (rd_b),
    .sts          (sts_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r    <= WLW'(10);
      sg_r    <= swscf_pkg::GAIN_W'(512);
      sc_r    <= 1'b1;
      state_r <= T_IDLE;
      len_r   <= LW'(1);
      seen_r  <= '0;
      k_r     <= '0;
      pend_r  <= '0;
      wptr_r  <= '0;
      tail_r  <= '0;
      lst_r   <= 1'b0;
      ph_r    <= 1'b0;
      all_r   <= 1'b0;
      judge_r <= 1'b0;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
      dn_r    <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      wl_r    <= wl_nxt;
      sg_r    <= sg_nxt;
      sc_r    <= sc_nxt;
      state_r <= state_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      k_r     <= k_nxt;
      pend_r  <= pend_nxt;
      wptr_r  <= wptr_nxt;
      tail_r  <= tail_nxt;
      lst_r   <= lst_nxt;
      ph_r    <= ph_nxt;
      all_r   <= all_nxt;
      judge_r <= judge_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
      dn_r    <= dn_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
    xa_r   <= xa_nxt;
    xb_r   <= xb_nxt;
    flag_r <= flag_nxt;
    of_r   <= of_nxt;
    on_r   <= on_nxt;
    ot_r   <= ot_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid         = ov_r;
  assign out_rfi_flag      = of_r;
  assign out_new_flag      = on_r;
  assign out_flagged_total = ot_r;
  assign out_last_res      = ol_r;

endmodule
